### sv/ordering_table_chain_checker_assert.svh
// Assertion macros for the ordering table chain checker.
// Used inside modules that have clk and rst_n in scope.
`ifndef ORDERING_TABLE_CHAIN_CHECKER_ASSERT_SVH
`define ORDERING_TABLE_CHAIN_CHECKER_ASSERT_SVH

// same-cycle implication
`define OTCC_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/otcc_pkg.sv
// Package for the ordering table chain checker: constants, microcode types,
// control and flag structs, address normalization. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package otcc_pkg;

  localparam logic [15:0] LIST_CAPACITY    = 16'd16384;
  localparam logic [63:0] HASH_BASIS       = 64'd1469598103934665603;
  // prime = 2^40 + 435
  localparam int          HASH_PRIME_SHIFT = 40;
  localparam logic [8:0]  HASH_PRIME_LO    = 9'd435;
  localparam logic [31:0] RAM_WORD_MASK    = 32'h001ffffc;
  localparam logic [31:0] CHAIN_END        = 32'h00ffffff;
  localparam logic [31:0] TAG_BEGIN        = 32'h4f54424c;
  localparam logic [31:0] TAG_END          = 32'h4f54454e;
  localparam logic [7:0]  MAX_PACKET       = 8'd255;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_NODE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_CYCLIC  = 2'd2;

  localparam logic [1:0] WHY_NONE     = 2'd0;
  localparam logic [1:0] WHY_INVALID  = 2'd1;
  localparam logic [1:0] WHY_CYCLIC   = 2'd2;
  localparam logic [1:0] WHY_OVERFLOW = 2'd3;

  typedef logic [4:0] pc_t;

  localparam pc_t PC_DISPATCH = 5'd0;
  localparam pc_t PC_BEGIN    = 5'd1;
  localparam pc_t PC_NODE     = 5'd5;
  localparam pc_t PC_END      = 5'd11;
  localparam pc_t PC_FAIL_INV = 5'd16;
  localparam pc_t PC_FAIL_CYC = 5'd17;
  localparam pc_t PC_FAIL_OVF = 5'd18;
  localparam pc_t PC_EMIT     = 5'd19;

  typedef enum logic [3:0] {
    FS_NONE,
    FS_TAG_BEGIN,
    FS_ADDR,
    FS_LISTS,
    FS_NEXT,
    FS_WORDS,
    FS_ORD,
    FS_TAG_END,
    FS_STATUS
  } fold_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_OPEN,
    ACT_COUNT,
    ACT_CLOSE,
    ACT_LIST_INC,
    ACT_FAIL
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_BEGIN_INV,
    C_NODE_INV,
    C_NODE_OVF,
    C_NOT_OPEN,
    C_LIST_MAX,
    C_STAT_CYC,
    C_STAT_OK
  } cond_t;

  typedef struct packed {
    fold_sel_t  fold_sel;
    act_t       act;
    logic [1:0] reason;
    cond_t      cond;
    pc_t        target;
    logic       dispatch;
    logic       emit;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       failed;
    logic       begin_inv;
    logic       node_inv;
    logic       node_ovf;
    logic       not_open;
    logic       list_max;
    logic       stat_cyc;
    logic       stat_ok;
  } flags_t;

  typedef struct packed {
    logic        ok;
    logic [23:0] norm;
  } ram_word_t;

  function automatic ram_word_t to_ram_word(input logic [31:0] addr);
    ram_word_t  r;
    logic [2:0] seg;
    seg    = addr[31:29];
    r.ok   = (seg == 3'b000 || seg == 3'b100 || seg == 3'b101) &&
             (addr[28:21] == 8'd0) && (addr[1:0] == 2'd0);
    r.norm = addr[23:0] & RAM_WORD_MASK[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/otcc_ifs.sv
// Valid/ready channel interfaces for event beats and result beats.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface otcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] address;
  logic [31:0] next_address;
  logic [15:0] word_count;
  logic [31:0] ordinal;
  logic [1:0]  end_status;

  modport source (output valid, operation, address, next_address, word_count, ordinal,
                  end_status, input ready);
  modport sink (input valid, operation, address, next_address, word_count, ordinal,
                end_status, output ready);
endinterface

interface otcc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;
  logic [31:0] list_total;
  logic [31:0] node_total;
  logic [31:0] word_total;
  logic        list_open;
  logic        failed;
  logic [1:0]  fail_reason;

  modport source (output valid, digest, list_total, node_total, word_total, list_open,
                  failed, fail_reason, input ready);
  modport sink (input valid, digest, list_total, node_total, word_total, list_open,
                failed, fail_reason, output ready);
endinterface

`default_nettype wire

### sv/otcc_rom.sv
// Microcode store: one control word per step of the event program.
// Depends on otcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otcc_rom (
  input  otcc_pkg::pc_t  pc,
  output otcc_pkg::ctl_t ctl
);

  always_comb begin
    ctl.fold_sel = otcc_pkg::FS_NONE;
    ctl.act      = otcc_pkg::ACT_NONE;
    ctl.reason   = otcc_pkg::WHY_NONE;
    ctl.cond     = otcc_pkg::C_NEXT;
    ctl.target   = otcc_pkg::PC_DISPATCH;
    ctl.dispatch = 1'b0;
    ctl.emit     = 1'b0;
    case (pc)
      5'd0: begin
        ctl.dispatch = 1'b1;
      end
      // begin
      5'd1: begin
        ctl.cond   = otcc_pkg::C_BEGIN_INV;
        ctl.target = otcc_pkg::PC_FAIL_INV;
      end
      5'd2: begin
        ctl.fold_sel = otcc_pkg::FS_TAG_BEGIN;
        ctl.act      = otcc_pkg::ACT_OPEN;
      end
      5'd3: begin
        ctl.fold_sel = otcc_pkg::FS_ADDR;
      end
      5'd4: begin
        ctl.fold_sel = otcc_pkg::FS_LISTS;
        ctl.cond     = otcc_pkg::C_ALWAYS;
        ctl.target   = otcc_pkg::PC_EMIT;
      end
      // node
      5'd5: begin
        ctl.cond   = otcc_pkg::C_NODE_INV;
        ctl.target = otcc_pkg::PC_FAIL_INV;
      end
      5'd6: begin
        ctl.cond   = otcc_pkg::C_NODE_OVF;
        ctl.target = otcc_pkg::PC_FAIL_OVF;
      end
      5'd7: begin
        ctl.fold_sel = otcc_pkg::FS_ADDR;
        ctl.act      = otcc_pkg::ACT_COUNT;
      end
      5'd8: begin
        ctl.fold_sel = otcc_pkg::FS_NEXT;
      end
      5'd9: begin
        ctl.fold_sel = otcc_pkg::FS_WORDS;
      end
      5'd10: begin
        ctl.fold_sel = otcc_pkg::FS_ORD;
        ctl.cond     = otcc_pkg::C_ALWAYS;
        ctl.target   = otcc_pkg::PC_EMIT;
      end
      // end
      5'd11: begin
        ctl.act    = otcc_pkg::ACT_CLOSE;
        ctl.cond   = otcc_pkg::C_NOT_OPEN;
        ctl.target = otcc_pkg::PC_FAIL_INV;
      end
      5'd12: begin
        ctl.cond   = otcc_pkg::C_LIST_MAX;
        ctl.target = otcc_pkg::PC_FAIL_OVF;
      end
      5'd13: begin
        ctl.fold_sel = otcc_pkg::FS_TAG_END;
        ctl.act      = otcc_pkg::ACT_LIST_INC;
      end
      5'd14: begin
        ctl.fold_sel = otcc_pkg::FS_STATUS;
        ctl.cond     = otcc_pkg::C_STAT_CYC;
        ctl.target   = otcc_pkg::PC_FAIL_CYC;
      end
      5'd15: begin
        ctl.cond   = otcc_pkg::C_STAT_OK;
        ctl.target = otcc_pkg::PC_EMIT;
      end
      // failure latches
      5'd16: begin
        ctl.act    = otcc_pkg::ACT_FAIL;
        ctl.reason = otcc_pkg::WHY_INVALID;
        ctl.cond   = otcc_pkg::C_ALWAYS;
        ctl.target = otcc_pkg::PC_EMIT;
      end
      5'd17: begin
        ctl.act    = otcc_pkg::ACT_FAIL;
        ctl.reason = otcc_pkg::WHY_CYCLIC;
        ctl.cond   = otcc_pkg::C_ALWAYS;
        ctl.target = otcc_pkg::PC_EMIT;
      end
      5'd18: begin
        ctl.act    = otcc_pkg::ACT_FAIL;
        ctl.reason = otcc_pkg::WHY_OVERFLOW;
        ctl.cond   = otcc_pkg::C_ALWAYS;
        ctl.target = otcc_pkg::PC_EMIT;
      end
      default: begin
        ctl.emit = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/otcc_seq.sv
// Step counter and branch unit of the microcoded sequencer.
// Depends on otcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otcc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             out_hold,
  input  otcc_pkg::ctl_t   ctl,
  input  otcc_pkg::flags_t flags,
  output otcc_pkg::pc_t    pc,
  output logic             busy
);

  otcc_pkg::pc_t pc_r, pc_nxt, entry;
  logic          busy_r, busy_nxt;
  logic          take;

  always_comb begin
    case (ctl.cond)
      otcc_pkg::C_NEXT:      take = 1'b0;
      otcc_pkg::C_ALWAYS:    take = 1'b1;
      otcc_pkg::C_BEGIN_INV: take = flags.begin_inv;
      otcc_pkg::C_NODE_INV:  take = flags.node_inv;
      otcc_pkg::C_NODE_OVF:  take = flags.node_ovf;
      otcc_pkg::C_NOT_OPEN:  take = flags.not_open;
      otcc_pkg::C_LIST_MAX:  take = flags.list_max;
      otcc_pkg::C_STAT_CYC:  take = flags.stat_cyc;
      otcc_pkg::C_STAT_OK:   take = flags.stat_ok;
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    case (flags.op)
      otcc_pkg::OP_BEGIN: entry = otcc_pkg::PC_BEGIN;
      otcc_pkg::OP_NODE:  entry = otcc_pkg::PC_NODE;
      otcc_pkg::OP_END:   entry = otcc_pkg::PC_END;
      default:            entry = otcc_pkg::PC_EMIT;
    endcase
    if (flags.failed) begin
      entry = otcc_pkg::PC_EMIT;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = otcc_pkg::PC_DISPATCH;
      end
    end else if (ctl.emit) begin
      if (!out_hold) begin
        busy_nxt = 1'b0;
        pc_nxt   = otcc_pkg::PC_DISPATCH;
      end
    end else if (ctl.dispatch) begin
      pc_nxt = entry;
    end else if (take) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = pc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= otcc_pkg::PC_DISPATCH;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign pc   = pc_r;
  assign busy = busy_r;

endmodule

`default_nettype wire

### sv/otcc_dp.sv
// Datapath: captured event, chain state, totals, hash fold unit and
// result register. Driven by control words; depends on otcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otcc_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [1:0]       in_operation,
  input  logic [31:0]      in_address,
  input  logic [31:0]      in_next_address,
  input  logic [15:0]      in_word_count,
  input  logic [31:0]      in_ordinal,
  input  logic [1:0]       in_end_status,
  input  otcc_pkg::ctl_t   ctl,
  input  logic             out_load,
  output otcc_pkg::flags_t flags,
  output logic [63:0]      res_digest,
  output logic [31:0]      res_list_total,
  output logic [31:0]      res_node_total,
  output logic [31:0]      res_word_total,
  output logic             res_list_open,
  output logic             res_failed,
  output logic [1:0]       res_fail_reason
);

  // captured beat
  logic [1:0]  op_r;
  logic [31:0] addr_r, next_r, ord_r;
  logic [15:0] words_r;
  logic [1:0]  status_r;

  // chain state
  logic [63:0] hash_r, hash_nxt;
  logic [31:0] lists_r, lists_nxt;
  logic [31:0] nodes_r, nodes_nxt;
  logic [31:0] wtot_r, wtot_nxt;
  logic        open_r, open_nxt;
  logic [15:0] nil_r, nil_nxt;
  logic [23:0] exp_r, exp_nxt;
  logic        failed_r, failed_nxt;
  logic [1:0]  reason_r, reason_nxt;

  otcc_pkg::ram_word_t a_w, n_w;
  logic        next_is_end;
  logic [23:0] norm_next;
  logic [32:0] words_sum;
  logic [31:0] fv;
  logic [63:0] hx, hmul, hmix;

  always_comb begin
    a_w         = otcc_pkg::to_ram_word(addr_r);
    n_w         = otcc_pkg::to_ram_word(next_r);
    next_is_end = (next_r == otcc_pkg::CHAIN_END);
    norm_next   = next_is_end ? otcc_pkg::CHAIN_END[23:0] : n_w.norm;
    words_sum   = {1'b0, wtot_r} + {17'd0, words_r};
  end

  always_comb begin
    flags.op        = op_r;
    flags.failed    = failed_r;
    flags.begin_inv = open_r || !a_w.ok;
    flags.node_inv  = !open_r || (words_r > {8'd0, otcc_pkg::MAX_PACKET}) || !a_w.ok ||
                      (a_w.norm != exp_r) || (ord_r != {16'd0, nil_r}) ||
                      (!next_is_end && !n_w.ok);
    flags.node_ovf  = (nil_r >= otcc_pkg::LIST_CAPACITY) || (nodes_r == 32'hffffffff) ||
                      words_sum[32];
    flags.not_open  = !open_r;
    flags.list_max  = (lists_r == 32'hffffffff);
    flags.stat_cyc  = (status_r == otcc_pkg::ST_CYCLIC);
    flags.stat_ok   = (status_r == otcc_pkg::ST_VALID);
  end

  // fold operand
  always_comb begin
    case (ctl.fold_sel)
      otcc_pkg::FS_TAG_BEGIN: fv = otcc_pkg::TAG_BEGIN;
      otcc_pkg::FS_ADDR:      fv = {8'd0, a_w.norm};
      otcc_pkg::FS_LISTS:     fv = lists_r;
      otcc_pkg::FS_NEXT:      fv = {8'd0, norm_next};
      otcc_pkg::FS_WORDS:     fv = {16'd0, words_r};
      otcc_pkg::FS_ORD:       fv = ord_r;
      otcc_pkg::FS_TAG_END:   fv = otcc_pkg::TAG_END;
      otcc_pkg::FS_STATUS:    fv = {30'd0, status_r};
      default:                fv = 32'd0;
    endcase
  end

  // h = (h ^ v) * (2^40 + 435)
  always_comb begin
    hx   = hash_r ^ {32'd0, fv};
    hmul = hx * otcc_pkg::HASH_PRIME_LO;
    hmix = (hx << otcc_pkg::HASH_PRIME_SHIFT) + hmul;
  end

  always_comb begin
    hash_nxt   = hash_r;
    lists_nxt  = lists_r;
    nodes_nxt  = nodes_r;
    wtot_nxt   = wtot_r;
    open_nxt   = open_r;
    nil_nxt    = nil_r;
    exp_nxt    = exp_r;
    failed_nxt = failed_r;
    reason_nxt = reason_r;
    if (ctl.fold_sel != otcc_pkg::FS_NONE) begin
      hash_nxt = hmix;
    end
    case (ctl.act)
      otcc_pkg::ACT_OPEN: begin
        open_nxt = 1'b1;
        nil_nxt  = 16'd0;
        exp_nxt  = a_w.norm;
      end
      otcc_pkg::ACT_COUNT: begin
        nodes_nxt = nodes_r + 32'd1;
        wtot_nxt  = words_sum[31:0];
        exp_nxt   = norm_next;
        nil_nxt   = nil_r + 16'd1;
      end
      otcc_pkg::ACT_CLOSE: begin
        open_nxt = 1'b0;
        nil_nxt  = 16'd0;
        exp_nxt  = 24'd0;
      end
      otcc_pkg::ACT_LIST_INC: begin
        lists_nxt = lists_r + 32'd1;
      end
      otcc_pkg::ACT_FAIL: begin
        failed_nxt = 1'b1;
        reason_nxt = ctl.reason;
        open_nxt   = 1'b0;
        nil_nxt    = 16'd0;
        exp_nxt    = 24'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= otcc_pkg::HASH_BASIS;
      lists_r  <= 32'd0;
      nodes_r  <= 32'd0;
      wtot_r   <= 32'd0;
      open_r   <= 1'b0;
      nil_r    <= 16'd0;
      exp_r    <= 24'd0;
      failed_r <= 1'b0;
      reason_r <= otcc_pkg::WHY_NONE;
    end else begin
      hash_r   <= hash_nxt;
      lists_r  <= lists_nxt;
      nodes_r  <= nodes_nxt;
      wtot_r   <= wtot_nxt;
      open_r   <= open_nxt;
      nil_r    <= nil_nxt;
      exp_r    <= exp_nxt;
      failed_r <= failed_nxt;
      reason_r <= reason_nxt;
    end
  end

  // beat capture; a valid end status on an empty or unterminated list is demoted
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_operation;
      addr_r   <= in_address;
      next_r   <= in_next_address;
      words_r  <= in_word_count;
      ord_r    <= in_ordinal;
      status_r <= in_end_status;
    end else if (ctl.act == otcc_pkg::ACT_CLOSE && status_r == otcc_pkg::ST_VALID &&
                 (nil_r == 16'd0 || exp_r != otcc_pkg::CHAIN_END[23:0])) begin
      status_r <= otcc_pkg::ST_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_digest      <= hash_r;
      res_list_total  <= lists_r;
      res_node_total  <= nodes_r;
      res_word_total  <= wtot_r;
      res_list_open   <= open_r;
      res_failed      <= failed_r;
      res_fail_reason <= reason_r;
    end
  end

endmodule

`default_nettype wire

### sv/ordering_table_chain_checker.sv
// Top level of the ordering table chain checker: sequencer, microcode
// store, datapath and result handshake. Depends on otcc_pkg, otcc_ifs,
// otcc_rom, otcc_seq, otcc_dp and the assertion macro header.
//
// Usage:
//   in_ch carries one event beat (begin, node or end); out_ch returns one
//   result beat per event with the hash and totals after that event.
//   One event is in work at a time; in_ch.ready is high while idle.
//   Each event runs from the dispatch step through its begin, node or
//   end steps to the result; an ignored event, or any event after a
//   failure, goes from dispatch straight to the result. The next input
//   beat can be taken in the cycle after the result is registered; the
//   step program runs one hash fold per cycle through a single shift-add
//   multiplier.
//   Reset (rst_n low, synchronous) loads the hash basis, clears totals,
//   closes any list and clears the failure latch; out_ch.valid drops.
//   When out_ch.ready is low the finished result waits in the output
//   register; the next event can be accepted and run up to its final step,
//   where it waits until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none

module ordering_table_chain_checker (
  input  logic       clk,
  input  logic       rst_n,
  otcc_in_if.sink    in_ch,
  otcc_out_if.source out_ch
);

  otcc_pkg::ctl_t   ctl;
  otcc_pkg::flags_t flags;
  otcc_pkg::pc_t    pc;
  logic             busy;
  logic             in_fire;
  logic             out_hold;
  logic             out_load;
  logic             out_valid_r, out_valid_nxt;

  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && !busy;
  assign out_hold    = out_valid_r && !out_ch.ready;
  assign out_load    = busy && ctl.emit && !out_hold;

  otcc_rom u_rom (
    .pc  (pc),
    .ctl (ctl)
  );

  otcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .out_hold (out_hold),
    .ctl      (ctl),
    .flags    (flags),
    .pc       (pc),
    .busy     (busy)
  );

  otcc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .in_operation    (in_ch.operation),
    .in_address      (in_ch.address),
    .in_next_address (in_ch.next_address),
    .in_word_count   (in_ch.word_count),
    .in_ordinal      (in_ch.ordinal),
    .in_end_status   (in_ch.end_status),
    .ctl             (ctl),
    .out_load        (out_load),
    .flags           (flags),
    .res_digest      (out_ch.digest),
    .res_list_total  (out_ch.list_total),
    .res_node_total  (out_ch.node_total),
    .res_word_total  (out_ch.word_total),
    .res_list_open   (out_ch.list_open),
    .res_failed      (out_ch.failed),
    .res_fail_reason (out_ch.fail_reason)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

`include "ordering_table_chain_checker_assert.svh"

  `OTCC_ASSERT_NEXT(a_accept_starts, in_fire, busy, "accepted beat did not start the sequencer")
  `OTCC_ASSERT_NEXT(a_fail_sticky, flags.failed, flags.failed, "failure latch cleared")
  `OTCC_ASSERT_HOLDS(a_reason_match, out_ch.valid, out_ch.failed == (out_ch.fail_reason != otcc_pkg::WHY_NONE), "fail reason disagrees with failed")
  `OTCC_ASSERT_HOLDS(a_open_vs_fail, out_ch.valid, !(out_ch.list_open && out_ch.failed), "list open after failure")

endmodule

`default_nettype wire
